@@ sv/sps_pkg.sv @@
// Shared types and codes for the LIFO stack with search.
package sps_pkg;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic               found;
    logic [7:0]         entry_count;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
    logic run;
  } cell_ctl_t;

endpackage

@@ sv/stack_push_pop_search.sv @@
// LIFO stack of signed 32-bit words with search, built as a shifting chain of cells.
//
// Input channel in_valid/in_ready/in_item carries one command (push, pop,
// search) and a value. Output channel out_valid/out_ready/out_item gives one
// result per command: status, popped word, found flag and the entry count
// after the command. The top of the stack sits in cell 0; push and pop shift
// the whole chain by one cell in the accept cycle.
// Push, pop and unused commands: result registered in the cycle after accept;
// a new item can be taken every cycle while the output is free or drained.
// Search: the hit flag ripples one cell per cycle through all DEPTH cells
// in state S_SRCH; the result, taken from the last cell, is registered once
// state S_DONE finds the output free, and no item is taken meanwhile.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result. When out_ready is low the result holds in the output register,
// and in_ready stays low until that register can take the next result.
module stack_push_pop_search
  import sps_pkg::*;
#(
  parameter int DEPTH = 128
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [TW-1:0]      step_r, step_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               out_free, acc, do_push, do_pop, is_srch;
  cell_ctl_t          ctl;
  logic signed [31:0] cell_data [DEPTH];
  logic               cell_hit  [DEPTH];

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign acc      = in_valid && in_ready;
  assign do_push  = acc && (in_item.command == CMD_PUSH) && (count_r != CW'(DEPTH));
  assign do_pop   = acc && (in_item.command == CMD_POP) && (count_r != '0);
  assign is_srch  = acc && (in_item.command == CMD_SEARCH);

  always_comb begin
    ctl.push = do_push;
    ctl.pop  = do_pop;
    ctl.clr  = is_srch;
    ctl.run  = (state_r == S_SRCH);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_d, next_d;
    logic               prev_h;
    if (i == 0) begin : g_top
      assign prev_d = in_item.value;
      assign prev_h = 1'b0;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
      assign prev_h = cell_hit[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign next_d = '0;
    end else begin : g_up
      assign next_d = cell_data[i+1];
    end
    sps_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (key_r),
      .live      (count_r > CW'(i)),
      .data_prev (prev_d),
      .data_next (next_d),
      .hit_prev  (prev_h),
      .data      (cell_data[i]),
      .hit       (cell_hit[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    case (state_r)
      S_IDLE: begin
        if (is_srch) begin
          state_nxt = S_SRCH;
          step_nxt  = '0;
          key_nxt   = in_item.value;
        end else if (acc) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = ST_OK;
          out_item_nxt.popped_value = '0;
          out_item_nxt.found        = 1'b0;
          out_item_nxt.entry_count  = 8'(count_nxt);
          if (in_item.command == CMD_PUSH && !do_push) begin
            out_item_nxt.status = ST_FULL;
          end
          if (in_item.command == CMD_POP) begin
            if (do_pop) begin
              out_item_nxt.popped_value = cell_data[0];
            end else begin
              out_item_nxt.status = ST_EMPTY;
            end
          end
        end
      end
      S_SRCH: begin
        step_nxt = step_r + TW'(1);
        if (step_r == TW'(DEPTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt                 = S_IDLE;
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = ST_OK;
          out_item_nxt.popped_value = '0;
          out_item_nxt.found        = cell_hit[DEPTH-1];
          out_item_nxt.entry_count  = 8'(count_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sv/sps_cell.sv @@
// One stack cell: holds a word, shifts with its neighbors, passes the search hit down.
module sps_cell
  import sps_pkg::*;
(
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] key,
  input  logic               live,
  input  logic signed [31:0] data_prev,
  input  logic signed [31:0] data_next,
  input  logic               hit_prev,
  output logic signed [31:0] data,
  output logic               hit
);

  logic signed [31:0] data_r, data_nxt;
  logic               hit_r, hit_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = data_prev;
    end else if (ctl.pop) begin
      data_nxt = data_next;
    end
  end

  always_comb begin
    hit_nxt = hit_r;
    if (ctl.clr) begin
      hit_nxt = 1'b0;
    end else if (ctl.run) begin
      hit_nxt = hit_prev | (live && (data_r == key));
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule
